// File: design/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Shared types and constants for the thermistor ADC to temperature block.
// ----------------------------------------------------------------------------
package tad_pkg;

	localparam int LN_TABLE_ENTRIES_DEF = 64;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERIES     = 3'd0,
		REG_FULL_SCALE = 3'd1,
		REG_VREF       = 3'd2,
		REG_COEF_A     = 3'd3,
		REG_COEF_B     = 3'd4,
		REG_COEF_C     = 3'd5
	} cfg_reg_t;

	localparam logic [15:0]        RST_SERIES     = 16'd10000;
	localparam logic [15:0]        RST_FULL_SCALE = 16'd4095;
	localparam logic [15:0]        RST_VREF       = 16'd3300;
	localparam logic signed [31:0] RST_COEF_A     = 32'sd1109681000;
	localparam logic signed [31:0] RST_COEF_B     = 32'sd261508000;
	localparam logic signed [31:0] RST_COEF_C     = 32'sd222014;

	// ln(2) in Q30
	localparam logic [34:0] LN2_Q30 = 35'd744261118;

	// denominator at 2^40 scale and the final quotient
	localparam int DEN_W = 50;
	localparam int QUO_W = 47;

	typedef struct packed {
		logic        sample_zero;
		logic        res_bad;
		logic        den_bad;
		logic [15:0] res;
		logic [15:0] mv;
	} tad_side_t;

endpackage

// File: design/tad_div.sv
// ----------------------------------------------------------------------------
// tad_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tad_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [NW];
	logic [DW-1:0] rem_s  [NW];
	logic [NW-1:0] num_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          vld_in;
		logic [DW-1:0] rem_in;
		logic [NW-1:0] num_in;
		logic [NW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] sd_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign sd_in  = side_in;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign sd_in  = side_s[k-1];
		end

		assign trial = {rem_in, num_in[NW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
				num_s[k]  <= num_in << 1;
				quo_s[k]  <= {quo_in[NW-2:0], ge};
				den_s[k]  <= den_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

// File: design/tad_ln.sv
// ----------------------------------------------------------------------------
// tad_ln
// Natural log by table and interpolation, then the Steinhart-Hart denominator.
// ----------------------------------------------------------------------------
module tad_ln #(
	parameter int LnEntries = tad_pkg::LN_TABLE_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [31:0]                           r,
	input  tad_pkg::tad_side_t                    side_in,
	input  logic signed [31:0]                    coef_a,
	input  logic signed [31:0]                    coef_b,
	input  logic signed [31:0]                    coef_c,
	output logic                                  out_valid,
	output logic signed [tad_pkg::DEN_W-1:0]      den,
	output tad_pkg::tad_side_t                    side_out
);

	localparam int RomAw  = $clog2(LnEntries + 1);
	localparam int PosW   = 30 + RomAw;
	localparam int Stages = 11;
	localparam logic [RomAw-1:0] NMul = RomAw'(LnEntries);

	typedef logic [31:0] rom_t [0:LnEntries];

	// long division for building the table at elaboration
	function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] rr;
		q  = '0;
		rr = '0;
		for (int j = 63; j >= 0; j--) begin
			rr = {rr[63:0], a[j]};
			if (rr >= {1'b0, b}) begin
				rr   = rr - {1'b0, b};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// entry i is ln(1 + i/N) in Q30 via 2*atanh(i/(2N+i))
	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] n;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] sum;
		n = 64'(LnEntries);
		for (int i = 0; i <= LnEntries; i++) begin
			z    = cdiv(64'(i) << 30, 2 * n + 64'(i));
			z2   = (z * z) >> 30;
			term = z;
			sum  = '0;
			for (int k = 0; k < 24; k++) begin
				sum  = sum + cdiv(term, 64'(2 * k + 1));
				term = (term * z2) >> 30;
			end
			t[i] = 32'(2 * sum);
		end
		return t;
	endfunction

	localparam rom_t LnRom = build_rom();

	logic               vld_s  [Stages];
	tad_pkg::tad_side_t side_s [Stages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Stages; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < Stages; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < Stages; i++) side_s[i] <= side_s[i-1];
		end
	end

	// stage 1: leading one within each byte
	logic [3:0]  nz_c;
	logic [2:0]  top_c [4];
	logic [31:0] r_s1;
	logic [3:0]  nz_s1;
	logic [2:0]  top_s1 [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			nz_c[c]  = |r[8*c +: 8];
			top_c[c] = '0;
			for (int b = 0; b < 8; b++) begin
				if (r[8*c + b]) top_c[c] = 3'(b);
			end
		end
	end

	// stage 2: combine bytes into the msb position
	logic [4:0]  msb_c;
	logic [4:0]  msb_s2;
	logic [31:0] r_s2;

	always_comb begin
		msb_c = '0;
		for (int c = 0; c < 4; c++) begin
			if (nz_s1[c]) msb_c = {2'(c), top_s1[c]};
		end
	end

	// stage 3: normalise to 1.x in Q30
	logic [31:0] norm_c;
	logic [29:0] frac_s3;
	logic [4:0]  msb_s3;

	always_comb begin
		if (msb_s2 == 5'd31) begin
			norm_c = r_s2 >> 1;
		end else begin
			norm_c = r_s2 << (5'd30 - msb_s2);
		end
	end

	// stage 4: table position
	logic [PosW-1:0]  pos_c;
	logic [RomAw-1:0] idx_s4;
	logic [29:0]      rem_s4;
	logic [4:0]       msb_s4;

	assign pos_c = {{RomAw{1'b0}}, frac_s3} * {30'b0, NMul};

	// stage 5: table read
	logic [RomAw-1:0] idx_p1;
	logic [31:0]      lo_s5;
	logic [31:0]      hi_s5;
	logic [29:0]      rem_s5;
	logic [4:0]       msb_s5;

	assign idx_p1 = idx_s4 + RomAw'(1);

	// stage 6: interpolation product and integer part
	logic [61:0] interp_c;
	logic [61:0] interp_s6;
	logic [34:0] base_s6;

	assign interp_c = {30'b0, 32'(hi_s5 - lo_s5)} * {32'b0, rem_s5};

	// stage 7: ln in Q30, reduced to Q24
	logic [34:0] l30_c;
	logic [28:0] l24_s7;

	assign l30_c = base_s6 + 35'(interp_s6[61:30]);

	// stage 8: square
	logic [57:0] sq_s8;
	logic [28:0] l24_s8;

	// stage 9: cube and B term
	logic [62:0]        cube_s9;
	logic signed [61:0] bprod_s9;

	// stage 10: C term
	logic signed [63:0] cprod_s10;
	logic signed [37:0] bterm_s10;

	// stage 11: denominator
	logic signed [tad_pkg::DEN_W-1:0] den_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r;
			nz_s1  <= nz_c;
			top_s1 <= top_c;

			msb_s2 <= msb_c;
			r_s2   <= r_s1;

			frac_s3 <= norm_c[29:0];
			msb_s3  <= msb_s2;

			idx_s4 <= pos_c[PosW-1:30];
			rem_s4 <= pos_c[29:0];
			msb_s4 <= msb_s3;

			lo_s5  <= LnRom[idx_s4];
			hi_s5  <= LnRom[idx_p1];
			rem_s5 <= rem_s4;
			msb_s5 <= msb_s4;

			interp_s6 <= interp_c;
			base_s6   <= 35'(35'(msb_s5) * tad_pkg::LN2_Q30) + 35'(lo_s5);

			l24_s7 <= l30_c[34:6];

			sq_s8  <= {29'b0, l24_s7} * {29'b0, l24_s7};
			l24_s8 <= l24_s7;

			cube_s9  <= {29'b0, sq_s8[57:24]} * {34'b0, l24_s8};
			bprod_s9 <= $signed({{30{coef_b[31]}}, coef_b}) * $signed({33'b0, l24_s8});

			cprod_s10 <= $signed({{32{coef_c[31]}}, coef_c})
				* $signed({33'b0, cube_s9[62:32]});
			bterm_s10 <= bprod_s9[61:24];

			den_s11 <= {{(tad_pkg::DEN_W-32){coef_a[31]}}, coef_a}
				+ {{(tad_pkg::DEN_W-38){bterm_s10[37]}}, bterm_s10}
				+ {{(tad_pkg::DEN_W-48){cprod_s10[63]}}, cprod_s10[63:16]};
		end
	end

	assign out_valid = vld_s[Stages-1];
	assign side_out  = side_s[Stages-1];
	assign den       = den_s11;

endmodule

// File: design/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// Thermistor ADC code to resistance, millivolts and centidegrees Celsius.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries adc_sample; output channel
// out_valid/out_ready carries temp_centi, resistance_ohm, millivolts, fault.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
// registers; cfg_ready is always high and writes are meant for an idle block.
// From acceptance to out_valid an item passes one input stage, a
// 32-stage divider for resistance and millivolts, one stage to form the
// resistance, 11 stages of log and polynomial, a 47-stage divider for the
// reciprocal and the output register.
// Throughput is one item per cycle while the receiver takes results: every
// stage holds one item and all stages advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults; the table
// of logarithms is constant, so there is no clearing pass.
// A zero sample, a non-positive resistance or denominator, or a
// temperature above range raises fault with a saturated temperature.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature #(
	parameter int LnEntries = tad_pkg::LN_TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    adc_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             temp_centi,
	output logic [15:0]                    resistance_ohm,
	output logic [15:0]                    millivolts,
	output logic                           fault,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam logic [tad_pkg::QUO_W-1:0] NumCenti = tad_pkg::QUO_W'(100) << 40;
	localparam logic [tad_pkg::QUO_W-1:0] QuoMax   = tad_pkg::QUO_W'(32767 + 27315);
	localparam logic [15:0]               Kelvin   = 16'd27315;

	// configuration registers
	logic [15:0]        series_q;
	logic [15:0]        full_scale_q;
	logic [15:0]        vref_q;
	logic signed [31:0] coef_a_q;
	logic signed [31:0] coef_b_q;
	logic signed [31:0] coef_c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q     <= tad_pkg::RST_SERIES;
			full_scale_q <= tad_pkg::RST_FULL_SCALE;
			vref_q       <= tad_pkg::RST_VREF;
			coef_a_q     <= tad_pkg::RST_COEF_A;
			coef_b_q     <= tad_pkg::RST_COEF_B;
			coef_c_q     <= tad_pkg::RST_COEF_C;
		end else if (cfg_valid) begin
			unique case (tad_pkg::cfg_reg_t'(cfg_index))
				tad_pkg::REG_SERIES:     series_q     <= cfg_data[15:0];
				tad_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data[15:0];
				tad_pkg::REG_VREF:       vref_q       <= cfg_data[15:0];
				tad_pkg::REG_COEF_A:     coef_a_q     <= cfg_data;
				tad_pkg::REG_COEF_B:     coef_b_q     <= cfg_data;
				tad_pkg::REG_COEF_C:     coef_c_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance every stage together unless a result is held
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: input register
	logic        v_s1;
	logic [15:0] sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) sample_s1 <= adc_sample;
	end

	// resistance and millivolt dividers
	logic        vd1;
	logic        vd2;
	logic [31:0] q_res;
	logic [31:0] q_mv;
	logic        sz_d;
	logic        fsz_d;

	tad_div #(.NW(32), .DW(16), .SW(1)) u_div_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      ({16'b0, series_q} * {16'b0, full_scale_q}),
		.den      (sample_s1),
		.side_in  (sample_s1 == 16'd0),
		.out_valid(vd1),
		.quo      (q_res),
		.side_out (sz_d)
	);

	tad_div #(.NW(32), .DW(16), .SW(1)) u_div_mv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      ({16'b0, sample_s1} * {16'b0, vref_q}),
		.den      (full_scale_q),
		.side_in  (full_scale_q == 16'd0),
		.out_valid(vd2),
		.quo      (q_mv),
		.side_out (fsz_d)
	);

	// stage 2: resistance, saturation and early faults
	logic [32:0]        r_c;
	logic               res_bad_c;
	tad_pkg::tad_side_t side_c;
	logic               v_s2;
	logic [31:0]        r_s2;
	tad_pkg::tad_side_t side_s2;

	assign r_c       = {1'b0, q_res} - {17'b0, series_q};
	assign res_bad_c = !sz_d && (r_c[32] || r_c == 33'd0);

	always_comb begin
		side_c.sample_zero = sz_d;
		side_c.res_bad     = res_bad_c;
		side_c.den_bad     = 1'b0;
		if (sz_d) begin
			side_c.res = 16'hFFFF;
		end else if (res_bad_c) begin
			side_c.res = 16'd0;
		end else if (|r_c[31:16]) begin
			side_c.res = 16'hFFFF;
		end else begin
			side_c.res = r_c[15:0];
		end
		if (fsz_d || |q_mv[31:16]) begin
			side_c.mv = 16'hFFFF;
		end else begin
			side_c.mv = q_mv[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= vd1 && vd2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2    <= (sz_d || res_bad_c) ? 32'd1 : r_c[31:0];
			side_s2 <= side_c;
		end
	end

	// log and denominator
	logic                             v_ln;
	logic signed [tad_pkg::DEN_W-1:0] den_ln;
	tad_pkg::tad_side_t               side_ln;
	tad_pkg::tad_side_t               side_dv;
	logic                             den_bad;

	tad_ln #(.LnEntries(LnEntries)) u_ln (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.r        (r_s2),
		.side_in  (side_s2),
		.coef_a   (coef_a_q),
		.coef_b   (coef_b_q),
		.coef_c   (coef_c_q),
		.out_valid(v_ln),
		.den      (den_ln),
		.side_out (side_ln)
	);

	assign den_bad = den_ln[tad_pkg::DEN_W-1] || den_ln == '0;

	always_comb begin
		side_dv         = side_ln;
		side_dv.den_bad = den_bad;
	end

	// reciprocal divider
	logic                      v_q;
	logic [tad_pkg::QUO_W-1:0] q_temp;
	tad_pkg::tad_side_t        side_q;

	tad_div #(.NW(tad_pkg::QUO_W), .DW(48), .SW($bits(tad_pkg::tad_side_t))) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_ln),
		.num      (NumCenti),
		.den      (den_bad ? 48'd1 : den_ln[47:0]),
		.side_in  (side_dv),
		.out_valid(v_q),
		.quo      (q_temp),
		.side_out (side_q)
	);

	// output register
	logic [15:0] temp_c;
	logic        fault_c;
	logic [15:0] temp_q;
	logic [15:0] res_q;
	logic [15:0] mv_q;
	logic        fault_q;

	always_comb begin
		fault_c = 1'b1;
		if (side_q.sample_zero) begin
			temp_c = 16'h8000;
		end else if (side_q.res_bad || side_q.den_bad || q_temp > QuoMax) begin
			temp_c = 16'h7FFF;
		end else begin
			temp_c  = q_temp[15:0] - Kelvin;
			fault_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q  <= temp_c;
			res_q   <= side_q.res;
			mv_q    <= side_q.mv;
			fault_q <= fault_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign temp_centi     = temp_q;
	assign resistance_ohm = res_q;
	assign millivolts     = mv_q;
	assign fault          = fault_q;

`ifndef SYNTHESIS
	a_ok_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fault |-> resistance_ohm != 16'd0)
		else $error("clean result with zero resistance");

	a_min_is_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && temp_centi == -16'sd32768 |-> fault)
		else $error("lowest temperature without fault");

	a_ok_above_zero_k: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fault |-> temp_centi >= -16'sd27315)
		else $error("clean temperature below absolute zero");

	a_ok_res_mv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault && temp_centi == -16'sd32768 |-> resistance_ohm == 16'hFFFF)
		else $error("zero sample without saturated resistance");
`endif

endmodule
